FILE: src/ifr_pkg.sv
`timescale 1ns / 1ps

package ifr_pkg;

   // Frame positions fit in one byte for every supported frame length.
   localparam int unsigned POS_W = 8;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SYNC_BYTE  = 8'hFA;
   localparam logic [7:0] START_BYTE = 8'hFF;

   localparam logic [7:0] TIME_ID_HI = 8'h10;
   localparam logic [7:0] TIME_ID_LO = 8'h60;
   localparam logic [7:0] QUAT_ID_HI = 8'h20;
   localparam logic [7:0] QUAT_ID_LO = 8'h10;
   localparam logic [7:0] RATE_ID_HI = 8'h80;
   localparam logic [7:0] RATE_ID_LO = 8'h20;

   // Fixed offsets inside the frame.
   localparam int unsigned TIME_ID_POS = 4;
   localparam int unsigned TIME_POS    = 7;
   localparam int unsigned QUAT_ID_POS = 11;
   localparam int unsigned QUAT_W_POS  = 14;
   localparam int unsigned QUAT_X_POS  = 18;
   localparam int unsigned QUAT_Y_POS  = 22;
   localparam int unsigned QUAT_Z_POS  = 26;
   localparam int unsigned RATE_ID_POS = 30;
   localparam int unsigned RATE_X_POS  = 33;
   localparam int unsigned RATE_Y_POS  = 37;
   localparam int unsigned RATE_Z_POS  = 41;

   // Only this window of the frame is ever looked at.
   localparam int unsigned CAPT_FIRST = 4;
   localparam int unsigned CAPT_LAST  = 44;

   typedef struct packed {
      logic [7:0]       data;
      logic [POS_W-1:0] pos;
      logic             last;
   } frame_word_type;

   typedef struct packed {
      logic           valid;
      frame_word_type word;
   } word_xfer_type;

   typedef struct packed {
      logic [31:0] sample_time;
      logic        time_valid;
      logic [31:0] quat_w;
      logic [31:0] quat_x;
      logic [31:0] quat_y;
      logic [31:0] quat_z;
      logic        quat_valid;
      logic [31:0] rate_x;
      logic [31:0] rate_y;
      logic [31:0] rate_z;
      logic        rate_valid;
   } result_type;

endpackage

FILE: src/ifr_if.sv
`timescale 1ns / 1ps

interface ifr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_time;
   logic        time_valid;
   logic [31:0] quat_w;
   logic [31:0] quat_x;
   logic [31:0] quat_y;
   logic [31:0] quat_z;
   logic        quat_valid;
   logic [31:0] rate_x;
   logic [31:0] rate_y;
   logic [31:0] rate_z;
   logic        rate_valid;

   modport source (
      output valid, input ready,
      output sample_time, time_valid, quat_w, quat_x, quat_y, quat_z, quat_valid,
      output rate_x, rate_y, rate_z, rate_valid
   );
   modport sink (
      input valid, output ready,
      input sample_time, time_valid, quat_w, quat_x, quat_y, quat_z, quat_valid,
      input rate_x, rate_y, rate_z, rate_valid
   );
endinterface

FILE: src/ifr_queue.sv
`timescale 1ns / 1ps

module ifr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ifr_pkg::word_xfer_type push,
   input  logic                   pop,
   output logic                   full,
   output ifr_pkg::word_xfer_type head
);
   import ifr_pkg::*;

   frame_word_type    entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign count_in = count_ff + QCNT_W'(push.valid) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.word;
      end
   end

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.word  = entry_ff[rd_ptr_ff];

endmodule

FILE: src/ifr_front.sv
`timescale 1ns / 1ps

module ifr_front #(
   parameter int unsigned FRAME_LEN = 46
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [7:0]             rx_byte,
   input  logic                   queue_full,
   output logic                   in_ready,
   output ifr_pkg::word_xfer_type push
);
   import ifr_pkg::*;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ARMED,
      ST_COLLECT
   } state_type;

   state_type        state_ff;
   logic [POS_W-1:0] pos_ff;
   logic             accept;
   logic             store;
   logic             is_last;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   // The start byte itself is the first stored word of the frame.
   assign store   = (state_ff == ST_COLLECT) ||
                    ((state_ff == ST_ARMED) && (rx_byte == START_BYTE));
   assign is_last = (pos_ff == LAST_POS);

   assign push.valid     = accept && store;
   assign push.word.data = rx_byte;
   assign push.word.pos  = pos_ff;
   assign push.word.last = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= POS_W'(1);
      end else if (accept) begin
         priority if (store && is_last) begin
            state_ff <= ST_IDLE;
            pos_ff   <= POS_W'(1);
         end else if (store) begin
            state_ff <= ST_COLLECT;
            pos_ff   <= pos_ff + POS_W'(1);
         end else if (rx_byte == SYNC_BYTE) begin
            state_ff <= ST_ARMED;
         end else begin
            state_ff <= state_ff;
         end
      end
   end

endmodule

FILE: src/ifr_back.sv
`timescale 1ns / 1ps

module ifr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ifr_pkg::word_xfer_type head,
   output logic                   pop,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output ifr_pkg::result_type    result
);
   import ifr_pkg::*;

   logic [7:0] frame_ff [CAPT_FIRST:CAPT_LAST];
   logic [7:0] cur      [CAPT_FIRST:CAPT_LAST];
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type result_ff;
   result_type result_in;
   logic       finish;
   logic       tv;
   logic       qv;
   logic       rv;

   // A closing word waits only while an untaken result sits in the output register.
   assign pop    = head.valid && (!head.word.last || !rsp_valid_ff || rsp_ready);
   assign finish = pop && head.word.last;

   // The closing word is folded in before the result is built.
   always_comb begin
      for (int i = CAPT_FIRST; i <= CAPT_LAST; i++) begin
         cur[i] = (pop && (head.word.pos == POS_W'(i))) ? head.word.data : frame_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = CAPT_FIRST; i <= CAPT_LAST; i++) begin
         if (pop && (head.word.pos == POS_W'(i))) begin
            frame_ff[i] <= head.word.data;
         end
      end
   end

   assign tv = (cur[TIME_ID_POS] == TIME_ID_HI) && (cur[TIME_ID_POS + 1] == TIME_ID_LO);
   assign qv = (cur[QUAT_ID_POS] == QUAT_ID_HI) && (cur[QUAT_ID_POS + 1] == QUAT_ID_LO);
   assign rv = (cur[RATE_ID_POS] == RATE_ID_HI) && (cur[RATE_ID_POS + 1] == RATE_ID_LO);

   always_comb begin
      result_in = '0;
      result_in.time_valid = tv;
      result_in.quat_valid = qv;
      result_in.rate_valid = rv;
      if (tv) begin
         result_in.sample_time = {cur[TIME_POS], cur[TIME_POS + 1],
                                  cur[TIME_POS + 2], cur[TIME_POS + 3]};
      end
      if (qv) begin
         result_in.quat_w = {cur[QUAT_W_POS], cur[QUAT_W_POS + 1],
                             cur[QUAT_W_POS + 2], cur[QUAT_W_POS + 3]};
         result_in.quat_x = {cur[QUAT_X_POS], cur[QUAT_X_POS + 1],
                             cur[QUAT_X_POS + 2], cur[QUAT_X_POS + 3]};
         result_in.quat_y = {cur[QUAT_Y_POS], cur[QUAT_Y_POS + 1],
                             cur[QUAT_Y_POS + 2], cur[QUAT_Y_POS + 3]};
         result_in.quat_z = {cur[QUAT_Z_POS], cur[QUAT_Z_POS + 1],
                             cur[QUAT_Z_POS + 2], cur[QUAT_Z_POS + 3]};
      end
      if (rv) begin
         result_in.rate_x = {cur[RATE_X_POS], cur[RATE_X_POS + 1],
                             cur[RATE_X_POS + 2], cur[RATE_X_POS + 3]};
         result_in.rate_y = {cur[RATE_Y_POS], cur[RATE_Y_POS + 1],
                             cur[RATE_Y_POS + 2], cur[RATE_Y_POS + 3]};
         result_in.rate_z = {cur[RATE_Z_POS], cur[RATE_Z_POS + 1],
                             cur[RATE_Z_POS + 2], cur[RATE_Z_POS + 3]};
      end
   end

   always_comb begin
      priority if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

FILE: src/imu_frame_receiver_top.sv
`timescale 1ns / 1ps

// Byte-serial receiver for a fixed-length IMU data frame.
// The req channel carries one received serial byte per word. A 0xFA byte arms
// the receiver, and the next 0xFF byte (not necessarily adjacent) opens a frame
// whose bytes fill positions 1 to FRAME_LEN-1.
// When the last position is filled, one word leaves on the rsp channel: sample
// time, quaternion and rate of turn, each with a flag that says whether its
// data identifier was found. A group whose flag is low reads as zero.
// Throughput is one byte per clock cycle while the queue has room. The classifier
// takes a byte in the cycle it arrives, a two-entry queue passes stored bytes to
// the extractor, and the extractor registers the result for rsp once the closing byte leaves the queue.
// While rsp is stalled, incoming bytes keep flowing until a second closing byte
// waits at the head of the queue; req_bus.ready then drops once the queue is full.
// Reset returns the receiver to idle, empties the queue and drops rsp valid;
// a partly received frame is discarded.
module imu_frame_receiver_top #(
   parameter int unsigned FRAME_LEN = 46
) (
   input  logic      clock,
   input  logic      reset,
   ifr_req_if.sink   req_bus,
   ifr_rsp_if.source rsp_bus
);
   import ifr_pkg::*;

   word_xfer_type push;
   word_xfer_type head;
   logic          queue_full;
   logic          pop;
   logic          rsp_valid;
   result_type    result;

   ifr_front #(
      .FRAME_LEN(FRAME_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .rx_byte   (req_bus.rx_byte),
      .queue_full(queue_full),
      .in_ready  (req_bus.ready),
      .push      (push)
   );

   ifr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .pop  (pop),
      .full (queue_full),
      .head (head)
   );

   ifr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_ready(rsp_bus.ready),
      .rsp_valid(rsp_valid),
      .result   (result)
   );

   assign rsp_bus.valid       = rsp_valid;
   assign rsp_bus.sample_time = result.sample_time;
   assign rsp_bus.time_valid  = result.time_valid;
   assign rsp_bus.quat_w      = result.quat_w;
   assign rsp_bus.quat_x      = result.quat_x;
   assign rsp_bus.quat_y      = result.quat_y;
   assign rsp_bus.quat_z      = result.quat_z;
   assign rsp_bus.quat_valid  = result.quat_valid;
   assign rsp_bus.rate_x      = result.rate_x;
   assign rsp_bus.rate_y      = result.rate_y;
   assign rsp_bus.rate_z      = result.rate_z;
   assign rsp_bus.rate_valid  = result.rate_valid;

endmodule

FILE: src/ifr_checker.sv
`timescale 1ns / 1ps

module ifr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] sample_time,
   input logic        time_valid,
   input logic [31:0] quat_w,
   input logic        quat_valid,
   input logic [31:0] rate_x,
   input logic        rate_valid
);

   // A new word can only come from an accepted byte that passed through the queue.
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response appeared without a closing byte two cycles before");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A group whose identifier was not found reads as zero.
   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((time_valid || sample_time == '0) &&
                     (quat_valid || quat_w == '0) &&
                     (rate_valid || rate_x == '0)))
      else $error("data of a missing group is not zero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(sample_time) && $stable(time_valid) &&
                                 $stable(quat_w) && $stable(quat_valid) &&
                                 $stable(rate_x) && $stable(rate_valid))
      else $error("response payload changed while stalled");

endmodule

bind imu_frame_receiver_top ifr_checker u_ifr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .sample_time(rsp_bus.sample_time),
   .time_valid (rsp_bus.time_valid),
   .quat_w     (rsp_bus.quat_w),
   .quat_valid (rsp_bus.quat_valid),
   .rate_x     (rsp_bus.rate_x),
   .rate_valid (rsp_bus.rate_valid)
);

FILE: tb/imu_frame_receiver_top_test.sv
`timescale 1ns / 1ps

module imu_frame_receiver_top_test;
   import ifr_pkg::*;

   localparam int unsigned FRAME_LEN     = 46;
   localparam int unsigned HALF_PERIOD   = 6;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES = 10;
   localparam int unsigned PHASE_ITEMS   = 300;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_SYNC} fill_kind_type;
   typedef enum int {ID_ABSENT, ID_PRESENT, ID_HALF} id_kind_type;

   logic clock;
   logic reset;

   ifr_req_if req_bus ();
   ifr_rsp_if rsp_bus ();

   imu_frame_receiver_top #(
      .FRAME_LEN(FRAME_LEN)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // Local copy of the receiver state, advanced on every accepted word.
   logic             rx_armed      = 1'b0;
   logic             rx_collecting = 1'b0;
   logic [POS_W-1:0] rx_pos        = POS_W'(1);
   logic [7:0]       frame_copy [FRAME_LEN];

   result_type  expected_results [$];
   int unsigned error_count    = 0;
   int unsigned items_driven   = 0;
   int unsigned frames_checked = 0;
   int unsigned time_hits      = 0;
   int unsigned quat_hits      = 0;
   int unsigned rate_hits      = 0;
   int unsigned idle_cycles    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned stall_pct      = 0;

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   function automatic logic [31:0] frame_word(input int unsigned p);
      return {frame_copy[p], frame_copy[p+1], frame_copy[p+2], frame_copy[p+3]};
   endfunction

   function automatic bit absorb_rx_byte(input logic [7:0] b, output result_type r);
      r = '0;
      if (b == SYNC_BYTE) begin
         rx_armed = 1'b1;
         frame_copy[0] = SYNC_BYTE;
      end
      if (rx_armed && b == START_BYTE) begin
         rx_collecting = 1'b1;
      end
      if (!(rx_armed && rx_collecting)) begin
         return 1'b0;
      end
      if (rx_pos < FRAME_LEN) begin
         frame_copy[rx_pos] = b;
         rx_pos++;
      end
      if (rx_pos < FRAME_LEN) begin
         return 1'b0;
      end
      rx_armed = 1'b0;
      rx_collecting = 1'b0;
      rx_pos = POS_W'(1);
      if (frame_copy[TIME_ID_POS] == TIME_ID_HI && frame_copy[TIME_ID_POS+1] == TIME_ID_LO) begin
         r.time_valid  = 1'b1;
         r.sample_time = frame_word(TIME_POS);
      end
      if (frame_copy[QUAT_ID_POS] == QUAT_ID_HI && frame_copy[QUAT_ID_POS+1] == QUAT_ID_LO) begin
         r.quat_valid = 1'b1;
         r.quat_w     = frame_word(QUAT_W_POS);
         r.quat_x     = frame_word(QUAT_X_POS);
         r.quat_y     = frame_word(QUAT_Y_POS);
         r.quat_z     = frame_word(QUAT_Z_POS);
      end
      if (frame_copy[RATE_ID_POS] == RATE_ID_HI && frame_copy[RATE_ID_POS+1] == RATE_ID_LO) begin
         r.rate_valid = 1'b1;
         r.rate_x     = frame_word(RATE_X_POS);
         r.rate_y     = frame_word(RATE_Y_POS);
         r.rate_z     = frame_word(RATE_Z_POS);
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Prediction on accepted bytes, checking on accepted results, and the watchdog.
   always @(posedge clock) begin : track_words
      result_type fresh;
      result_type want;
      bit         moved;

      moved = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            if (absorb_rx_byte(req_bus.rx_byte, fresh)) begin
               expected_results.push_back(fresh);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (expected_results.size() == 0) begin
               report_mismatch("result word arrived with no completed frame pending");
            end else begin
               want = expected_results.pop_front();
               frames_checked++;
               time_hits += want.time_valid;
               quat_hits += want.quat_valid;
               rate_hits += want.rate_valid;
               compare_field("sample_time", rsp_bus.sample_time, want.sample_time);
               compare_field("time_valid", 32'(rsp_bus.time_valid), 32'(want.time_valid));
               compare_field("quat_w", rsp_bus.quat_w, want.quat_w);
               compare_field("quat_x", rsp_bus.quat_x, want.quat_x);
               compare_field("quat_y", rsp_bus.quat_y, want.quat_y);
               compare_field("quat_z", rsp_bus.quat_z, want.quat_z);
               compare_field("quat_valid", 32'(rsp_bus.quat_valid), 32'(want.quat_valid));
               compare_field("rate_x", rsp_bus.rate_x, want.rate_x);
               compare_field("rate_y", rsp_bus.rate_y, want.rate_y);
               compare_field("rate_z", rsp_bus.rate_z, want.rate_z);
               compare_field("rate_valid", 32'(rsp_bus.rate_valid), 32'(want.rate_valid));
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_results.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Called at a rising edge; returns at the edge where the byte is accepted.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      items_driven++;
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (b == avoid);
      return b;
   endfunction

   function automatic logic [15:0] id_bytes(input id_kind_type kind, input logic [7:0] hi,
                                            input logic [7:0] lo, input logic [15:0] filler);
      case (kind)
         ID_PRESENT: return {hi, lo};
         ID_HALF:    return {hi, lo ^ 8'($urandom_range(1, 255))};
         default:    return filler;
      endcase
   endfunction

   // Sync byte, some ignored bytes, start byte, then the rest of the frame.
   task automatic send_frame(input id_kind_type t_id, input id_kind_type q_id,
                             input id_kind_type r_id, input fill_kind_type fill,
                             input int unsigned lead);
      logic [7:0] body [FRAME_LEN];

      for (int p = 2; p < FRAME_LEN; p++) begin
         case (fill)
            FILL_ZERO: body[p] = 8'h00;
            FILL_ONES: body[p] = 8'hFF;
            FILL_SYNC: body[p] = ($urandom_range(1)) ? SYNC_BYTE : 8'($urandom_range(255));
            default:   body[p] = 8'($urandom_range(255));
         endcase
      end
      {body[TIME_ID_POS], body[TIME_ID_POS+1]} =
         id_bytes(t_id, TIME_ID_HI, TIME_ID_LO, {body[TIME_ID_POS], body[TIME_ID_POS+1]});
      {body[QUAT_ID_POS], body[QUAT_ID_POS+1]} =
         id_bytes(q_id, QUAT_ID_HI, QUAT_ID_LO, {body[QUAT_ID_POS], body[QUAT_ID_POS+1]});
      {body[RATE_ID_POS], body[RATE_ID_POS+1]} =
         id_bytes(r_id, RATE_ID_HI, RATE_ID_LO, {body[RATE_ID_POS], body[RATE_ID_POS+1]});

      send_byte(SYNC_BYTE);
      repeat (lead) send_byte(byte_other_than(START_BYTE));
      send_byte(START_BYTE);
      for (int p = 2; p < FRAME_LEN; p++) begin
         send_byte(body[p]);
      end
   endtask

   function automatic id_kind_type pick_id_kind();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return ID_PRESENT;
      if (roll < 85) return ID_HALF;
      return ID_ABSENT;
   endfunction

   function automatic fill_kind_type pick_fill();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 80) return FILL_RANDOM;
      if (roll < 90) return FILL_SYNC;
      if (roll < 95) return FILL_ZERO;
      return FILL_ONES;
   endfunction

   // Without a sync byte first, nothing is stored; a lone sync byte only arms.
   task automatic test_ignored_bytes();
      send_byte(START_BYTE);
      send_byte(8'h00);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(SYNC_BYTE);
      send_byte(8'h00);
      send_byte(SYNC_BYTE);
      send_byte(8'h7F);
      wait_for_results();
   endtask

   task automatic test_field_extremes();
      send_frame(ID_PRESENT, ID_PRESENT, ID_PRESENT, FILL_ZERO, 0);
      send_frame(ID_PRESENT, ID_PRESENT, ID_PRESENT, FILL_ONES, 0);
      send_frame(ID_PRESENT, ID_PRESENT, ID_PRESENT, FILL_RANDOM, 0);
      wait_for_results();
   endtask

   // Absent groups must read as zero, including identifiers that miss by one byte.
   task automatic test_missing_groups();
      send_frame(ID_ABSENT, ID_ABSENT, ID_ABSENT, FILL_ONES, 0);
      send_frame(ID_HALF, ID_HALF, ID_HALF, FILL_RANDOM, 0);
      send_frame(ID_PRESENT, ID_ABSENT, ID_HALF, FILL_RANDOM, 0);
      send_frame(ID_HALF, ID_PRESENT, ID_ABSENT, FILL_RANDOM, 0);
      send_frame(ID_ABSENT, ID_HALF, ID_PRESENT, FILL_RANDOM, 0);
      wait_for_results();
   endtask

   task automatic test_sync_inside_frame();
      send_frame(ID_PRESENT, ID_PRESENT, ID_PRESENT, FILL_SYNC, 0);
      wait_for_results();
   endtask

   // Start byte well after the sync byte, and a start byte right after completion.
   task automatic test_frame_boundary();
      send_frame(ID_PRESENT, ID_PRESENT, ID_PRESENT, FILL_RANDOM, 4);
      send_byte(START_BYTE);
      send_byte(8'h01);
      send_frame(ID_PRESENT, ID_PRESENT, ID_PRESENT, FILL_RANDOM, 0);
      send_frame(ID_PRESENT, ID_ABSENT, ID_PRESENT, FILL_RANDOM, 1);
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned hold_pct,
                                      input int unsigned count);
      int unsigned target;
      int unsigned roll;

      send_idle_pct = send_pct;
      stall_pct     = hold_pct;
      target        = items_driven + count;
      while (items_driven < target) begin
         roll = $urandom_range(99);
         if (roll < 80) begin
            send_frame(pick_id_kind(), pick_id_kind(), pick_id_kind(), pick_fill(),
                       ($urandom_range(1)) ? 0 : $urandom_range(1, 4));
         end else if (roll < 88) begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
         end else if (roll < 96) begin
            // A cut-off frame; whatever follows is absorbed into it.
            send_byte(SYNC_BYTE);
            send_byte(START_BYTE);
            repeat ($urandom_range(1, FRAME_LEN - 3)) send_byte(8'($urandom_range(255)));
         end else begin
            wait_for_results();
         end
      end
      wait_for_results();
   endtask

   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_ignored_bytes();
      test_field_extremes();
      test_missing_groups();
      test_sync_inside_frame();
      test_frame_boundary();
      test_random_traffic(0, 0, PHASE_ITEMS);
      test_random_traffic(59, 0, PHASE_ITEMS);
      test_random_traffic(0, 59, PHASE_ITEMS);
      test_random_traffic(30, 30, PHASE_ITEMS);

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Drove %0d bytes under four idle and stall mixes; %0d frames checked.",
               items_driven, frames_checked);
      $display("Groups found: time %0d, quaternion %0d, rate of turn %0d; mismatches %0d.",
               time_hits, quat_hits, rate_hits, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: imu_frame_receiver_top.f
src/ifr_pkg.sv
src/ifr_if.sv
src/ifr_queue.sv
src/ifr_front.sv
src/ifr_back.sv
src/imu_frame_receiver_top.sv
src/ifr_checker.sv
tb/imu_frame_receiver_top_test.sv
